/* design/gcode_line_tokenizer_top_defines.svh */
// ----------------------------------------------------------------------------
// gcode line tokenizer assertion macros
// concurrent checks on clock and reset, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GCODE_LINE_TOKENIZER_TOP_DEFINES_SVH
`define GCODE_LINE_TOKENIZER_TOP_DEFINES_SVH
`ifndef SYNTH
`define GCLT_ASSERT(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("gclt check failed");
`define GCLT_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("gclt check failed");
`define GCLT_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("gclt check failed");
`else
`define GCLT_ASSERT(lbl, cond)
`define GCLT_ASSERT_IMP(lbl, pre, post)
`define GCLT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/gclt_pkg.sv */
// ----------------------------------------------------------------------------
// gclt_pkg
// shared types and constants of the gcode line tokenizer
// ----------------------------------------------------------------------------
package gclt_pkg;

   localparam int NUM_FLAGS = 12;
   localparam int WHOLE_W   = 31;
   localparam int FRAC_W    = 20;
   localparam int FCNT_W    = 3;
   localparam int LETTER_W  = 5;

   typedef struct packed {
      logic [LETTER_W-1:0]  letter;
      logic                 is_command;
      logic                 negative;
      logic [WHOLE_W-1:0]   whole_part;
      logic [FRAC_W-1:0]    fraction;
      logic [FCNT_W-1:0]    fraction_digits;
      logic [NUM_FLAGS-1:0] present_mask;
      logic                 line_done;
      logic                 bad_start;
      logic                 overflowed;
   } rsp_type;

endpackage

/* design/gclt_in_stage.sv */
// ----------------------------------------------------------------------------
// gclt_in_stage
// input register for the byte stream, advances when the output side moves
// ----------------------------------------------------------------------------
module gclt_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       req_valid,
   input  logic [7:0] req_char_in,
   output logic       byte_valid,
   output logic [7:0] byte_char
);

   logic       valid_ff;
   logic [7:0] char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         char_ff <= req_char_in;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_char  = char_ff;

endmodule

/* design/gclt_parser.sv */
// ----------------------------------------------------------------------------
// gclt_parser
// word state machine and number accumulators, one byte per step
// ----------------------------------------------------------------------------
module gclt_parser #(
   parameter int MAX_FRAC_DIGITS = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_valid,
   input  logic [7:0]       step_char,
   output logic             res_valid,
   output gclt_pkg::rsp_type res
);

   import gclt_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAC_DIGITS);
   localparam logic [WHOLE_W-1:0] WHOLE_MAX = '1;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [LETTER_W-1:0] LETTER_M = 5'd12;

   typedef enum logic [1:0] {
      PH_CMD,
      PH_CMD_NUM,
      PH_PARAM_NUM,
      PH_PARAM
   } phase_type;

   phase_type            phase_ff,       phase_in;
   logic [LETTER_W-1:0]  letter_ff,      letter_in;
   logic                 sign_ff,        sign_in;
   logic [WHOLE_W-1:0]   whole_ff,       whole_in;
   logic [FRAC_W-1:0]    frac_ff,        frac_in;
   logic [CNT_W-1:0]     fcnt_ff,        fcnt_in;
   logic                 point_ff,       point_in;
   logic [NUM_FLAGS-1:0] mask_ff,        mask_in;
   logic                 sat_ff,         sat_in;

   logic                 is_digit;
   logic [3:0]           digit;
   logic [WHOLE_W+3:0]   whole_mac;
   logic [FRAC_W-1:0]    frac_mac;
   logic                 int_only;
   logic                 is_param;
   logic                 has_flag;
   logic [3:0]           flag_idx;
   logic [CNT_W+2:0]     fcnt_ext;
   logic [LETTER_W-1:0]  new_letter;
   logic [7:0]           letter_diff;

   // parameter letter lookup: flag bit, or no flag for the axis letters
   always_comb begin
      is_param = 1'b1;
      has_flag = 1'b1;
      flag_idx = 4'd0;
      unique case (step_char)
         "F": flag_idx = 4'd0;
         "S": flag_idx = 4'd1;
         "H": flag_idx = 4'd2;
         "I": flag_idx = 4'd3;
         "J": flag_idx = 4'd4;
         "K": flag_idx = 4'd5;
         "L": flag_idx = 4'd6;
         "P": flag_idx = 4'd7;
         "R": flag_idx = 4'd8;
         "Q": flag_idx = 4'd9;
         "D": flag_idx = 4'd10;
         "M": flag_idx = 4'd11;
         "X", "Y", "Z": has_flag = 1'b0;
         default: begin
            is_param = 1'b0;
            has_flag = 1'b0;
         end
      endcase
   end

   assign letter_diff = step_char - CH_A;
   assign new_letter  = letter_diff[LETTER_W-1:0];
   assign is_digit    = (step_char >= CH_ZERO) && (step_char <= CH_NINE);
   assign digit       = step_char[3:0];
   // acc * 10 + d, anything past 31 bits saturates
   assign whole_mac   = ({4'b0, whole_ff} << 3) + ({4'b0, whole_ff} << 1)
                        + {(WHOLE_W)'(0), digit};
   assign frac_mac    = (frac_ff << 3) + (frac_ff << 1) + {(FRAC_W-4)'(0), digit};
   assign int_only    = (phase_ff == PH_CMD_NUM) || (letter_ff == LETTER_M);
   assign fcnt_ext    = {3'b000, fcnt_ff};

   always_comb begin
      phase_in  = phase_ff;
      letter_in = letter_ff;
      sign_in   = sign_ff;
      whole_in  = whole_ff;
      frac_in   = frac_ff;
      fcnt_in   = fcnt_ff;
      point_in  = point_ff;
      mask_in   = mask_ff;
      sat_in    = sat_ff;
      res_valid = 1'b0;
      res       = '0;

      unique case (phase_ff)
         PH_CMD_NUM, PH_PARAM_NUM: begin
            priority if (is_digit) begin
               if (!point_ff) begin
                  if (whole_mac[WHOLE_W+3:WHOLE_W] != 4'd0) begin
                     whole_in = WHOLE_MAX;
                     sat_in   = 1'b1;
                  end else begin
                     whole_in = whole_mac[WHOLE_W-1:0];
                  end
               end else if (fcnt_ff < CNT_MAX) begin
                  frac_in = frac_mac;
                  fcnt_in = fcnt_ff + CNT_W'(1);
               end
            end else if (step_char == CH_MINUS) begin
               sign_in = 1'b1;
            end else if (step_char == CH_POINT && !int_only && !point_ff) begin
               point_in = 1'b1;
            end else begin
               // word ends here; a space keeps the line going
               res_valid           = 1'b1;
               res.letter          = letter_ff;
               res.is_command      = (phase_ff == PH_CMD_NUM);
               res.negative        = sign_ff;
               res.whole_part      = whole_ff;
               res.fraction        = frac_ff;
               res.fraction_digits = fcnt_ext[2:0];
               res.present_mask    = mask_ff;
               res.line_done       = (step_char != CH_SPACE);
               res.overflowed      = sat_ff;
               phase_in            = (step_char == CH_SPACE) ? PH_PARAM : PH_CMD;
            end
         end
         PH_PARAM: begin
            if (is_param) begin
               letter_in = new_letter;
               sign_in   = 1'b0;
               whole_in  = '0;
               frac_in   = '0;
               fcnt_in   = '0;
               point_in  = 1'b0;
               sat_in    = 1'b0;
               if (has_flag) begin
                  mask_in = mask_ff | (NUM_FLAGS'(1) << flag_idx);
               end
               phase_in = PH_PARAM_NUM;
            end else begin
               res_valid        = 1'b1;
               res.present_mask = mask_ff;
               res.line_done    = 1'b1;
               phase_in         = PH_CMD;
            end
         end
         PH_CMD: begin
            mask_in = '0;
            if (step_char == CH_G || step_char == CH_M) begin
               letter_in = new_letter;
               sign_in   = 1'b0;
               whole_in  = '0;
               frac_in   = '0;
               fcnt_in   = '0;
               point_in  = 1'b0;
               sat_in    = 1'b0;
               phase_in  = PH_CMD_NUM;
            end else begin
               res_valid     = 1'b1;
               res.line_done = 1'b1;
               res.bad_start = 1'b1;
            end
         end
         default: begin
            phase_in = PH_CMD;
         end
      endcase

      if (!step_valid) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CMD;
         letter_ff <= '0;
         sign_ff   <= 1'b0;
         whole_ff  <= '0;
         frac_ff   <= '0;
         fcnt_ff   <= '0;
         point_ff  <= 1'b0;
         mask_ff   <= '0;
         sat_ff    <= 1'b0;
      end else if (step_valid) begin
         phase_ff  <= phase_in;
         letter_ff <= letter_in;
         sign_ff   <= sign_in;
         whole_ff  <= whole_in;
         frac_ff   <= frac_in;
         fcnt_ff   <= fcnt_in;
         point_ff  <= point_in;
         mask_ff   <= mask_in;
         sat_ff    <= sat_in;
      end
   end

endmodule

/* design/gcode_line_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// gcode_line_tokenizer_top
// splits a G-code line byte stream into command and parameter words
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while req_stall is low. The word that a
// byte ends goes out through the input register and the parser step into the
// output register. A byte that only extends a word yields nothing. The only
// stall source is the output register: while a word waits there under
// rsp_stall, req_stall is high. Each line must open with G or M; any other
// byte in that place gives a bad_start word with line_done set. present_mask
// is final on the word with line_done.
module gcode_line_tokenizer_top #(
   parameter int MAX_FRAC_DIGITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_letter,
   output logic        rsp_is_command,
   output logic        rsp_negative,
   output logic [30:0] rsp_whole_part,
   output logic [19:0] rsp_fraction,
   output logic [2:0]  rsp_fraction_digits,
   output logic [11:0] rsp_present_mask,
   output logic        rsp_line_done,
   output logic        rsp_bad_start,
   output logic        rsp_overflowed
);

   import gclt_pkg::*;

`include "gcode_line_tokenizer_top_defines.svh"

   logic       advance;
   logic       byte_valid;
   logic [7:0] byte_char;
   logic       res_valid;
   rsp_type    res;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   // pipeline moves unless a word sits stalled in the output register
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   gclt_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_valid),
      .req_char_in (req_char_in),
      .byte_valid  (byte_valid),
      .byte_char   (byte_char)
   );

   gclt_parser #(
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_valid (byte_valid && advance),
      .step_char  (byte_char),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_letter          = rsp_ff.letter;
   assign rsp_is_command      = rsp_ff.is_command;
   assign rsp_negative        = rsp_ff.negative;
   assign rsp_whole_part      = rsp_ff.whole_part;
   assign rsp_fraction        = rsp_ff.fraction;
   assign rsp_fraction_digits = rsp_ff.fraction_digits;
   assign rsp_present_mask    = rsp_ff.present_mask;
   assign rsp_line_done       = rsp_ff.line_done;
   assign rsp_bad_start       = rsp_ff.bad_start;
   assign rsp_overflowed      = rsp_ff.overflowed;

   `GCLT_ASSERT(a_stall_needs_word, !req_stall || rsp_valid)
   `GCLT_ASSERT_IMP(a_bad_start_ends_line, rsp_valid && rsp_bad_start,
      rsp_line_done && !rsp_is_command && rsp_present_mask == 12'd0)
   `GCLT_ASSERT_IMP(a_cmd_letter, rsp_valid && rsp_is_command,
      rsp_letter == 5'd6 || rsp_letter == 5'd12)
   `GCLT_ASSERT_IMP(a_sat_value, rsp_valid && rsp_overflowed,
      rsp_whole_part == 31'h7FFFFFFF)
   `GCLT_ASSERT_NEXT(a_stalled_byte_held, byte_valid && !advance,
      byte_valid && $stable(byte_char))

endmodule

/* test/tb_gcode_line_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// tb_gcode_line_tokenizer_top
// self-checking bench: feeds G-code bytes under random gaps and back-pressure,
// tokenizes the same stream in a local model and checks every word delivered
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gcode_line_tokenizer_top;
   import gclt_pkg::*;

   localparam int FRAC_LIMIT   = 6;
   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_BYTES = 1250;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 10;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int NO_FLAG_BIT  = -1;
   localparam int NOT_A_PARAM  = -2;
   localparam logic [31:0] WHOLE_LIMIT = 32'h7FFF_FFFF;
   localparam logic [4:0]  LETTER_M    = 5'("M" - "A");

   typedef enum logic [1:0] {
      EXPECT_CMD, CMD_NUMBER, PARAM_NUMBER, EXPECT_PARAM
   } parse_phase_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [4:0]  rsp_letter;
   logic        rsp_is_command;
   logic        rsp_negative;
   logic [30:0] rsp_whole_part;
   logic [19:0] rsp_fraction;
   logic [2:0]  rsp_fraction_digits;
   logic [11:0] rsp_present_mask;
   logic        rsp_line_done;
   logic        rsp_bad_start;
   logic        rsp_overflowed;

   gcode_line_tokenizer_top #(
      .MAX_FRAC_DIGITS(FRAC_LIMIT)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_in         (req_char_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_letter          (rsp_letter),
      .rsp_is_command      (rsp_is_command),
      .rsp_negative        (rsp_negative),
      .rsp_whole_part      (rsp_whole_part),
      .rsp_fraction        (rsp_fraction),
      .rsp_fraction_digits (rsp_fraction_digits),
      .rsp_present_mask    (rsp_present_mask),
      .rsp_line_done       (rsp_line_done),
      .rsp_bad_start       (rsp_bad_start),
      .rsp_overflowed      (rsp_overflowed)
   );

   // flagged letters first, in present_mask bit order, then the unflagged axes
   string param_letters = "FSHIJKLPRQDMXYZ";

   // tokenizer model state
   parse_phase_type phase_q;
   logic [4:0]   word_letter_q;
   logic         minus_q;
   logic         point_q;
   logic         saturated_q;
   logic [31:0]  whole_q;
   logic [31:0]  frac_q;
   int           frac_digits_q;
   logic [11:0]  flags_q;
   rsp_type      pending_words[$];

   logic [7:0]   line_text[$];
   int           burst_left;
   int           bytes_sent;
   int           mismatches;
   int           words_checked;
   int           lines_closed;
   int           bad_starts;
   int           saturations;
   int           holds_done;
   logic         hold_request;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      #TIMEOUT_NS;
      $display("gcode_line_tokenizer_top regression: fail");
      $finish;
   end

   function automatic int flag_bit(input logic [7:0] c);
      for (int i = 0; i < param_letters.len(); i++)
         if (param_letters[i] == c) return (i < NUM_FLAGS) ? i : NO_FLAG_BIT;
      return NOT_A_PARAM;
   endfunction

   function automatic void open_word(input logic [7:0] c);
      word_letter_q = 5'(c - "A");
      minus_q       = 1'b0;
      point_q       = 1'b0;
      saturated_q   = 1'b0;
      whole_q       = '0;
      frac_q        = '0;
      frac_digits_q = 0;
   endfunction

   function automatic void queue_word(input logic [4:0] letter, input logic cmd, neg,
                                      input logic [31:0] whole, frac, input int fcnt,
                                      input logic done, bad, ovf);
      rsp_type w;
      w.letter          = letter;
      w.is_command      = cmd;
      w.negative        = neg;
      w.whole_part      = whole[WHOLE_W-1:0];
      w.fraction        = frac[FRAC_W-1:0];
      w.fraction_digits = fcnt[FCNT_W-1:0];
      w.present_mask    = flags_q;
      w.line_done       = done;
      w.bad_start       = bad;
      w.overflowed      = ovf;
      pending_words.push_back(w);
   endfunction

   // advance the model by one accepted byte
   function automatic void tokenize_char(input logic [7:0] c);
      logic [31:0] d;
      logic        int_only;
      int          fb;
      case (phase_q)
         CMD_NUMBER, PARAM_NUMBER: begin
            int_only = (phase_q == CMD_NUMBER) || (word_letter_q == LETTER_M);
            if (c >= "0" && c <= "9") begin
               d = 32'(c) - 32'("0");
               if (!point_q) begin
                  if (whole_q > (WHOLE_LIMIT - d) / 10) begin
                     whole_q     = WHOLE_LIMIT;
                     saturated_q = 1'b1;
                  end else begin
                     whole_q = whole_q * 10 + d;
                  end
               end else if (frac_digits_q < FRAC_LIMIT) begin
                  frac_q = frac_q * 10 + d;
                  frac_digits_q++;
               end
            end else if (c == "-") begin
               minus_q = 1'b1;
            end else if (c == "." && !int_only && !point_q) begin
               point_q = 1'b1;
            end else begin
               queue_word(word_letter_q, phase_q == CMD_NUMBER, minus_q, whole_q, frac_q,
                          frac_digits_q, c != " ", 1'b0, saturated_q);
               phase_q = (c == " ") ? EXPECT_PARAM : EXPECT_CMD;
            end
         end
         EXPECT_PARAM: begin
            fb = flag_bit(c);
            if (fb != NOT_A_PARAM) begin
               open_word(c);
               if (fb >= 0) flags_q[fb] = 1'b1;
               phase_q = PARAM_NUMBER;
            end else begin
               queue_word('0, 1'b0, 1'b0, '0, '0, 0, 1'b1, 1'b0, 1'b0);
               phase_q = EXPECT_CMD;
            end
         end
         default: begin
            flags_q = '0;
            if (c == "G" || c == "M") begin
               open_word(c);
               phase_q = CMD_NUMBER;
            end else begin
               queue_word('0, 1'b0, 1'b0, '0, '0, 0, 1'b1, 1'b1, 1'b0);
            end
         end
      endcase
   endfunction

   // offer one byte, hold it until taken; called and returns at a falling edge
   task automatic send_char(input logic [7:0] c);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid   = 1'b0;
            req_char_in = 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   = 1'b1;
      req_char_in = c;
      do @(posedge clock); while (req_stall);
      tokenize_char(c);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic void add_number(input logic int_only);
      int n_whole;
      int n_frac;
      case ($urandom_range(0, 9))
         0:       n_whole = 0;
         1:       n_whole = $urandom_range(10, 12);
         default: n_whole = $urandom_range(1, 4);
      endcase
      if ($urandom_range(0, 4) == 0) line_text.push_back("-");
      repeat (n_whole) begin
         line_text.push_back(8'("0" + $urandom_range(0, 9)));
         if ($urandom_range(0, 29) == 0) line_text.push_back("-");
      end
      if (!int_only && $urandom_range(0, 2) == 0) begin
         line_text.push_back(".");
         n_frac = $urandom_range(0, 8);
         repeat (n_frac) line_text.push_back(8'("0" + $urandom_range(0, 9)));
      end
   endfunction

   task automatic send_random_line();
      int         n_params;
      logic [7:0] letter;
      line_text.delete();
      line_text.push_back($urandom_range(0, 1) ? "G" : "M");
      add_number(1'b1);
      n_params = $urandom_range(0, 6);
      repeat (n_params) begin
         line_text.push_back(" ");
         letter = param_letters[$urandom_range(0, param_letters.len() - 1)];
         line_text.push_back(letter);
         add_number(letter == "M");
      end
      case ($urandom_range(0, 5))
         0, 1: line_text.push_back("\n");
         2:    line_text.push_back(";");
         3: begin
            // space then a byte that cannot open a parameter word
            line_text.push_back(" ");
            line_text.push_back($urandom_range(0, 1) ? "\n" : " ");
         end
         4:       line_text.push_back(8'($urandom_range(0, 255)));
         default: line_text.push_back(".");
      endcase
      if ($urandom_range(0, 9) == 0)
         line_text[$urandom_range(0, line_text.size() - 1)] = 8'($urandom_range(0, 255));
      foreach (line_text[i]) send_char(line_text[i]);
   endtask

   task automatic test_bad_start();
      send_text("Z");
      send_char(8'h00);
      send_char(8'hFF);
      send_text("\n");
   endtask

   task automatic test_command_words();
      // saturated negative command, '.' ends an integer-only word and the line
      send_text("M3000000000-.");
      // empty command number, then a space not followed by a letter
      send_text("G 5");
   endtask

   task automatic test_param_words();
      // seventh fraction digit dropped, second point ends the line
      send_text("G1 F.1234567.");
      send_text("M2 M7.");
   endtask

   task automatic test_back_pressure();
      hold_request = 1'b1;
      send_text("G1 X1 Y2 Z3 F4 S5\n");
   endtask

   task automatic test_random_stream();
      int goal;
      goal = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < goal) begin
         if ($urandom_range(0, 99) < 85) begin
            send_random_line();
         end else begin
            repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // receiver: stall pattern that changes mode every so often
   initial begin
      stall_mode_type stall_mode;
      int          mode_left;
      int          period;
      int          cycle_no;
      int          held;
      rsp_stall  = 1'b0;
      stall_mode = STALL_NONE;
      mode_left  = 0;
      period     = 2;
      cycle_no   = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_request = 1'b0;
            holds_done++;
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
            period     = $urandom_range(2, 5);
         end
         mode_left--;
         cycle_no++;
         case (stall_mode)
            STALL_NONE:  rsp_stall = 1'b0;
            STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall = ($urandom_range(0, 9) < 7);
            default:     rsp_stall = (cycle_no % period) != 0;
         endcase
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: word %0d field %s expected %0d actual %0d",
                     $time, words_checked, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected word, letter %0d line_done %0d",
                        $time, rsp_letter, rsp_line_done);
         end else begin
            want = pending_words.pop_front();
            check_field("letter", want.letter, rsp_letter);
            check_field("is_command", want.is_command, rsp_is_command);
            check_field("negative", want.negative, rsp_negative);
            check_field("whole_part", want.whole_part, rsp_whole_part);
            check_field("fraction", want.fraction, rsp_fraction);
            check_field("fraction_digits", want.fraction_digits, rsp_fraction_digits);
            check_field("present_mask", want.present_mask, rsp_present_mask);
            check_field("line_done", want.line_done, rsp_line_done);
            check_field("bad_start", want.bad_start, rsp_bad_start);
            check_field("overflowed", want.overflowed, rsp_overflowed);
            words_checked++;
            if (want.line_done) lines_closed++;
            if (want.bad_start) bad_starts++;
            if (want.overflowed) saturations++;
         end
      end
   end

   initial begin
      int waited;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_in   = '0;
      hold_request  = 1'b0;
      phase_q       = EXPECT_CMD;
      word_letter_q = '0;
      minus_q       = 1'b0;
      point_q       = 1'b0;
      saturated_q   = 1'b0;
      whole_q       = '0;
      frac_q        = '0;
      frac_digits_q = 0;
      flags_q       = '0;
      burst_left    = 0;
      bytes_sent    = 0;
      mismatches    = 0;
      words_checked = 0;
      lines_closed  = 0;
      bad_starts    = 0;
      saturations   = 0;
      holds_done    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_bad_start();
      test_command_words();
      test_param_words();
      test_back_pressure();
      test_random_stream();

      req_valid = 1'b0;
      waited = 0;
      while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d bytes, %0d words checked over %0d lines",
               bytes_sent, words_checked, lines_closed);
      $display("bad line starts %0d, saturated numbers %0d, long output holds %0d",
               bad_starts, saturations, holds_done);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("gcode_line_tokenizer_top regression: pass");
      end else begin
         $display("%0d mismatches, %0d words never delivered",
                  mismatches, pending_words.size());
         $display("gcode_line_tokenizer_top regression: fail");
      end
      $finish;
   end

endmodule

/* gcode_line_tokenizer_top.f */
+incdir+design
design/gclt_pkg.sv
design/gclt_in_stage.sv
design/gclt_parser.sv
design/gcode_line_tokenizer_top.sv
test/tb_gcode_line_tokenizer_top.sv
